// ===== sv/zmd_pkg.sv =====
`timescale 1ns / 1ps

package zmd_pkg;

  // Zone grid and frame limits
  localparam int ZONE_COLS    = 4;
  localparam int ZONE_ROWS    = 3;
  localparam int NZONES       = ZONE_COLS * ZONE_ROWS;
  localparam int START_DELAY  = 200;
  localparam int MAX_FRAME_MB = 128;

  // Field and register widths
  localparam int SAD_W      = 16;
  localparam int SIZE_W     = 8;
  localparam int ENABLE_W   = 12;
  localparam int LEVEL_W    = 2;
  localparam int CVAL_W     = 10;
  localparam int CFG_DATA_W = 12;
  localparam int CFG_IDX_W  = 3;
  localparam int OUT_TDATA_W = 16;

  // Internal widths
  localparam int CNT_W    = 15;
  localparam int CNT_MAX  = (2 ** CNT_W) - 1;
  localparam int POS_W    = $clog2(MAX_FRAME_MB);
  localparam int FWE_W    = $clog2(MAX_FRAME_MB + 1);
  localparam int FWX_W    = FWE_W + 1;
  localparam int ZC_W     = $clog2(ZONE_COLS + 1);
  localparam int ZR_W     = $clog2(ZONE_ROWS + 1);
  localparam int FRAMES_W = 8;
  localparam int AREA_W   = 2 * SIZE_W;
  localparam int MASK_W   = (NZONES > ENABLE_W) ? NZONES : ENABLE_W;

  // Shared divider
  localparam int DIV_W     = AREA_W;
  localparam int DVS_W     = CVAL_W;
  localparam int DIV_STEPS = DIV_W;
  localparam int STEP_W    = $clog2(DIV_STEPS);

  // Register reset values
  localparam logic [SIZE_W-1:0]   FW_RST   = SIZE_W'(120);
  localparam logic [SIZE_W-1:0]   WW_RST   = SIZE_W'(30);
  localparam logic [SIZE_W-1:0]   WH_RST   = SIZE_W'(22);
  localparam logic [ENABLE_W-1:0] ZEN_RST  = '0;
  localparam logic                CEN_RST  = 1'b0;
  localparam logic [LEVEL_W-1:0]  LVL_RST  = LEVEL_W'(1);
  localparam logic [CVAL_W-1:0]   CVAL_RST = '0;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_FRAME_WIDTH   = 3'd0,
    CFG_WINDOW_WIDTH  = 3'd1,
    CFG_WINDOW_HEIGHT = 3'd2,
    CFG_ZONE_ENABLE   = 3'd3,
    CFG_CUSTOM_ENABLE = 3'd4,
    CFG_SENS_LEVEL    = 3'd5,
    CFG_CUSTOM_VALUE  = 3'd6
  } cfg_idx_e;

  typedef enum logic [2:0] {
    ST_SETUP,
    ST_THR,
    ST_COL,
    ST_ROW,
    ST_RUN,
    ST_EVAL
  } state_e;

  typedef struct packed {
    logic             flush;
    logic             start;
    logic [DIV_W-1:0] dividend;
    logic [DVS_W-1:0] divisor;
  } div_req_t;

  typedef struct packed {
    logic             busy;
    logic             done;
    logic [DIV_W-1:0] quot;
    logic [DVS_W-1:0] rem;
  } div_rsp_t;

  // Sensitivity per width tier (rows) and level (columns)
  localparam logic [6:0] SENS_TBL [4][3] = '{
    '{7'd3,  7'd5,  7'd10},
    '{7'd7,  7'd11, 7'd20},
    '{7'd15, 7'd25, 7'd50},
    '{7'd35, 7'd55, 7'd95}
  };

  function automatic logic [FWE_W-1:0] eff_fw(logic [SIZE_W-1:0] fw);
    logic [FWE_W-1:0] r;
    if (fw == '0) begin
      r = FWE_W'(1);
    end else if (int'(fw) > MAX_FRAME_MB) begin
      r = FWE_W'(MAX_FRAME_MB);
    end else begin
      r = FWE_W'(fw);
    end
    return r;
  endfunction

  function automatic logic [SIZE_W-1:0] eff_size(logic [SIZE_W-1:0] s);
    return (s == '0) ? SIZE_W'(1) : s;
  endfunction

  function automatic logic [DVS_W-1:0] sens_of(logic [FWE_W-1:0] fw, logic cen,
                                               logic [LEVEL_W-1:0] lvl,
                                               logic [CVAL_W-1:0] cval);
    logic [DVS_W-1:0] s;
    logic [1:0]       tier;
    logic [17:0]      prod;
    logic [7:0]       q5;
    s    = DVS_W'(1);
    prod = 18'(cval) * 18'(205);
    q5   = prod[17:10];
    if (int'(fw) >= 120)     tier = 2'd3;
    else if (int'(fw) >= 80) tier = 2'd2;
    else if (int'(fw) >= 40) tier = 2'd1;
    else                     tier = 2'd0;
    if (!cen) begin
      if (lvl != LEVEL_W'(3)) s = DVS_W'(SENS_TBL[tier][lvl]);
    end else if (cval == '0) begin
      s = DVS_W'(20);
    end else if (int'(fw) > 45) begin
      s = (cval >= CVAL_W'(20)) ? DVS_W'(cval) : DVS_W'(20);
    end else begin
      // divide by five through the reciprocal, exact below 1024
      s = (q5 < 8'd10) ? DVS_W'(10) : DVS_W'(q5);
    end
    return (s == '0) ? DVS_W'(1) : s;
  endfunction

  function automatic logic [SAD_W-1:0] sad_thr_of(logic [AREA_W-1:0] area);
    logic [SAD_W-1:0] t;
    if (area >= AREA_W'(600))      t = SAD_W'(2500);
    else if (area >= AREA_W'(300)) t = SAD_W'(3000);
    else if (area >= AREA_W'(100)) t = SAD_W'(3500);
    else if (area >= AREA_W'(20))  t = SAD_W'(4000);
    else                           t = SAD_W'(4500);
    return t;
  endfunction

endpackage

// ===== sv/zmd_divider.sv =====
`timescale 1ns / 1ps

module zmd_divider
  import zmd_pkg::*;
(
  input  logic     clk_i,
  input  logic     rst_ni,
  input  div_req_t req_i,
  output div_rsp_t rsp_o
);

  logic              busy_q, busy_d;
  logic              done_q, done_d;
  logic [STEP_W-1:0] step_q, step_d;
  logic [DIV_W-1:0]  dq_q, dq_d;
  logic [DVS_W-1:0]  rem_q, rem_d;
  logic [DVS_W-1:0]  dvs_q, dvs_d;
  logic [DVS_W:0]    shifted;
  logic [DVS_W+1:0]  diff;

  // Restoring division, one quotient bit per cycle
  always_comb begin
    shifted = {rem_q, dq_q[DIV_W-1]};
    diff    = {1'b0, shifted} - {2'b00, dvs_q};
    busy_d  = busy_q;
    done_d  = 1'b0;
    step_d  = step_q;
    dq_d    = dq_q;
    rem_d   = rem_q;
    dvs_d   = dvs_q;
    if (req_i.flush) begin
      busy_d = 1'b0;
    end else if (busy_q) begin
      rem_d  = diff[DVS_W+1] ? shifted[DVS_W-1:0] : diff[DVS_W-1:0];
      dq_d   = {dq_q[DIV_W-2:0], ~diff[DVS_W+1]};
      step_d = step_q + STEP_W'(1);
      if (step_q == STEP_W'(DIV_STEPS - 1)) begin
        busy_d = 1'b0;
        done_d = 1'b1;
      end
    end else if (req_i.start) begin
      busy_d = 1'b1;
      step_d = '0;
      dq_d   = req_i.dividend;
      rem_d  = '0;
      dvs_d  = req_i.divisor;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      step_q <= '0;
    end else begin
      busy_q <= busy_d;
      done_q <= done_d;
      step_q <= step_d;
    end
  end

  always_ff @(posedge clk_i) begin
    dq_q  <= dq_d;
    rem_q <= rem_d;
    dvs_q <= dvs_d;
  end

  assign rsp_o.busy = busy_q;
  assign rsp_o.done = done_q;
  assign rsp_o.quot = dq_q;
  assign rsp_o.rem  = rem_q;

endmodule

// ===== sv/zone_motion_detector.sv =====
`timescale 1ns / 1ps

// Zone motion detector. Macroblock SADs of a frame arrive in raster order on the
// s_axis channel, one transfer per macroblock, tlast on the final one and the
// key-frame flag in tuser. One result per frame leaves on m_axis: per-zone motion
// flags and an any-motion bit in tdata, the evaluated flag in tuser.
// Throughput: one macroblock per cycle while s_axis_tready is high; each frame then
// passes through the zone evaluation state after its last macroblock. The result
// is registered there and held in an output register until taken.
// Setup: after reset and after every register write, a sequencer recomputes the
// thresholds and the zone position of the current macroblock with one shared
// 16-step divider (three divisions); s_axis_tready stays low until it finishes.
// Reset clears the frame position, zone counts and frame counter and loads the
// register defaults. When m_axis stalls, the result waits in its register and
// s_axis_tready drops until the slot is free again.
// Write registers with cfg_we_i only while no frame is in flight.

module zone_motion_detector
  import zmd_pkg::*;
(
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  logic                   s_axis_tvalid,
  output logic                   s_axis_tready,
  input  logic [SAD_W-1:0]       s_axis_tdata,   // [15:0] sad
  input  logic                   s_axis_tuser,   // [0] key_frame
  input  logic                   s_axis_tlast,
  output logic                   m_axis_tvalid,
  input  logic                   m_axis_tready,
  output logic [OUT_TDATA_W-1:0] m_axis_tdata,   // [11:0] zone_motion, [12] any_motion
  output logic                   m_axis_tuser,   // [0] evaluated
  input  logic                   cfg_we_i,
  input  logic [CFG_IDX_W-1:0]   cfg_idx_i,
  input  logic [CFG_DATA_W-1:0]  cfg_data_i
);

  state_e state_q, state_d;

  logic [SIZE_W-1:0]   fw_q, ww_q, wh_q;
  logic [ENABLE_W-1:0] zen_q;
  logic                cen_q;
  logic [LEVEL_W-1:0]  lvl_q;
  logic [CVAL_W-1:0]   cval_q;

  logic [AREA_W-1:0] area_q, area_d;
  logic [DVS_W-1:0]  sens_q, sens_d;
  logic [SAD_W-1:0]  sad_thr_q, sad_thr_d;
  logic [DIV_W-1:0]  cnt_thr_q, cnt_thr_d;

  logic [POS_W-1:0]  col_pos_q, col_pos_d, row_pos_q, row_pos_d;
  logic [SIZE_W-1:0] ccnt_q, ccnt_d, rcnt_q, rcnt_d;
  logic [ZC_W-1:0]   zc_q, zc_d;
  logic [ZR_W-1:0]   zr_q, zr_d;
  logic [CNT_W-1:0]  counts_q [NZONES];
  logic [CNT_W-1:0]  counts_d [NZONES];
  logic [FRAMES_W-1:0] frames_q, frames_d;
  logic              key_q, key_d;

  logic                out_valid_q, out_valid_d;
  logic [ENABLE_W-1:0] out_motion_q, out_motion_d;
  logic                out_any_q, out_any_d;
  logic                out_eval_q, out_eval_d;

  logic [FWE_W-1:0]  fw_eff;
  logic [SIZE_W-1:0] ww_eff, wh_eff;
  logic [AREA_W-1:0] area_now;
  logic              accept;
  logic              hit;
  logic              eval_ok;
  logic [MASK_W-1:0] zen_ext, motion_ext;
  logic [FWX_W-1:0]  col_next;
  logic [SIZE_W:0]   ccnt_next, rcnt_next;

  div_req_t div_req;
  div_rsp_t div_rsp;

  zmd_divider u_divider (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .req_i  (div_req),
    .rsp_o  (div_rsp)
  );

  assign fw_eff    = eff_fw(fw_q);
  assign ww_eff    = eff_size(ww_q);
  assign wh_eff    = eff_size(wh_q);
  assign area_now  = AREA_W'(ww_eff) * AREA_W'(wh_eff);
  assign accept    = s_axis_tvalid && s_axis_tready;
  assign col_next  = FWX_W'(col_pos_q) + FWX_W'(1);
  assign ccnt_next = {1'b0, ccnt_q} + (SIZE_W+1)'(1);
  assign rcnt_next = {1'b0, rcnt_q} + (SIZE_W+1)'(1);
  assign hit       = (FWE_W'(col_pos_q) < fw_eff) && (s_axis_tdata > sad_thr_q);
  assign eval_ok   = !key_q && (int'(frames_q) >= START_DELAY);
  assign zen_ext   = MASK_W'(zen_q);

  // Register file
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      fw_q   <= FW_RST;
      ww_q   <= WW_RST;
      wh_q   <= WH_RST;
      zen_q  <= ZEN_RST;
      cen_q  <= CEN_RST;
      lvl_q  <= LVL_RST;
      cval_q <= CVAL_RST;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_i)
        CFG_FRAME_WIDTH:   fw_q   <= cfg_data_i[SIZE_W-1:0];
        CFG_WINDOW_WIDTH:  ww_q   <= cfg_data_i[SIZE_W-1:0];
        CFG_WINDOW_HEIGHT: wh_q   <= cfg_data_i[SIZE_W-1:0];
        CFG_ZONE_ENABLE:   zen_q  <= cfg_data_i[ENABLE_W-1:0];
        CFG_CUSTOM_ENABLE: cen_q  <= cfg_data_i[0];
        CFG_SENS_LEVEL:    lvl_q  <= cfg_data_i[LEVEL_W-1:0];
        CFG_CUSTOM_VALUE:  cval_q <= cfg_data_i[CVAL_W-1:0];
        default: ;
      endcase
    end
  end

  // Next state
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      ST_SETUP: state_d = ST_THR;
      ST_THR:   if (div_rsp.done) state_d = ST_COL;
      ST_COL:   if (div_rsp.done) state_d = ST_ROW;
      ST_ROW:   if (div_rsp.done) state_d = ST_RUN;
      ST_RUN:   if (accept && s_axis_tlast) state_d = ST_EVAL;
      ST_EVAL:  state_d = ST_RUN;
      default:  state_d = ST_SETUP;
    endcase
    // any register write restarts the setup sequence
    if (cfg_we_i) state_d = ST_SETUP;
  end

  // Sequencer outputs and datapath
  always_comb begin
    area_d       = area_q;
    sens_d       = sens_q;
    sad_thr_d    = sad_thr_q;
    cnt_thr_d    = cnt_thr_q;
    col_pos_d    = col_pos_q;
    row_pos_d    = row_pos_q;
    ccnt_d       = ccnt_q;
    rcnt_d       = rcnt_q;
    zc_d         = zc_q;
    zr_d         = zr_q;
    counts_d     = counts_q;
    frames_d     = frames_q;
    key_d        = key_q;
    out_valid_d  = out_valid_q && !m_axis_tready;
    out_motion_d = out_motion_q;
    out_any_d    = out_any_q;
    out_eval_d   = out_eval_q;
    motion_ext   = '0;
    s_axis_tready = 1'b0;

    div_req.flush    = cfg_we_i;
    div_req.start    = 1'b0;
    div_req.dividend = area_q;
    div_req.divisor  = sens_q;

    unique case (state_q)
      ST_SETUP: begin
        area_d    = area_now;
        sens_d    = sens_of(fw_eff, cen_q, lvl_q, cval_q);
        sad_thr_d = sad_thr_of(area_now);
      end
      ST_THR: begin
        div_req.start = !div_rsp.busy && !div_rsp.done;
        if (div_rsp.done) cnt_thr_d = div_rsp.quot;
      end
      ST_COL: begin
        div_req.start    = !div_rsp.busy && !div_rsp.done;
        div_req.dividend = DIV_W'(col_pos_q);
        div_req.divisor  = DVS_W'(ww_eff);
        if (div_rsp.done) begin
          zc_d   = (div_rsp.quot >= DIV_W'(ZONE_COLS)) ? ZC_W'(ZONE_COLS)
                                                      : div_rsp.quot[ZC_W-1:0];
          ccnt_d = div_rsp.rem[SIZE_W-1:0];
        end
      end
      ST_ROW: begin
        div_req.start    = !div_rsp.busy && !div_rsp.done;
        div_req.dividend = DIV_W'(row_pos_q);
        div_req.divisor  = DVS_W'(wh_eff);
        if (div_rsp.done) begin
          zr_d   = (div_rsp.quot >= DIV_W'(ZONE_ROWS)) ? ZR_W'(ZONE_ROWS)
                                                      : div_rsp.quot[ZR_W-1:0];
          rcnt_d = div_rsp.rem[SIZE_W-1:0];
        end
      end
      ST_RUN: begin
        s_axis_tready = !out_valid_q || m_axis_tready;
        if (accept) begin
          for (int i = 0; i < ZONE_ROWS; i++) begin
            for (int j = 0; j < ZONE_COLS; j++) begin
              if (hit && zr_q == ZR_W'(i) && zc_q == ZC_W'(j) &&
                  counts_q[i*ZONE_COLS+j] != CNT_W'(CNT_MAX)) begin
                counts_d[i*ZONE_COLS+j] = counts_q[i*ZONE_COLS+j] + CNT_W'(1);
              end
            end
          end
          if (s_axis_tlast) begin
            key_d = s_axis_tuser;
            if (int'(frames_q) < START_DELAY) frames_d = frames_q + FRAMES_W'(1);
          end else if (col_next >= FWX_W'(fw_eff)) begin
            // wrap to the next macroblock row
            col_pos_d = '0;
            ccnt_d    = '0;
            zc_d      = '0;
            if (int'(row_pos_q) < MAX_FRAME_MB - 1) begin
              row_pos_d = row_pos_q + POS_W'(1);
              if (rcnt_next >= {1'b0, wh_eff}) begin
                rcnt_d = '0;
                if (zr_q != ZR_W'(ZONE_ROWS)) zr_d = zr_q + ZR_W'(1);
              end else begin
                rcnt_d = rcnt_next[SIZE_W-1:0];
              end
            end
          end else begin
            col_pos_d = col_next[POS_W-1:0];
            if (ccnt_next >= {1'b0, ww_eff}) begin
              ccnt_d = '0;
              if (zc_q != ZC_W'(ZONE_COLS)) zc_d = zc_q + ZC_W'(1);
            end else begin
              ccnt_d = ccnt_next[SIZE_W-1:0];
            end
          end
        end
      end
      ST_EVAL: begin
        for (int i = 0; i < ZONE_ROWS; i++) begin
          for (int j = 0; j < ZONE_COLS; j++) begin
            if (((ZONE_ROWS - 1 - i) * ZONE_COLS + j) < ENABLE_W && eval_ok &&
                ZR_W'(i) <= zr_q &&
                (AREA_W'(ww_eff) * AREA_W'(j)) < AREA_W'(fw_eff) &&
                zen_ext[(ZONE_ROWS - 1 - i) * ZONE_COLS + j] &&
                DIV_W'(counts_q[i*ZONE_COLS+j]) >= cnt_thr_q) begin
              motion_ext[(ZONE_ROWS - 1 - i) * ZONE_COLS + j] = 1'b1;
            end
          end
        end
        out_valid_d  = 1'b1;
        out_motion_d = motion_ext[ENABLE_W-1:0];
        out_any_d    = |motion_ext[ENABLE_W-1:0];
        out_eval_d   = eval_ok;
        col_pos_d    = '0;
        row_pos_d    = '0;
        ccnt_d       = '0;
        rcnt_d       = '0;
        zc_d         = '0;
        zr_d         = '0;
        for (int k = 0; k < NZONES; k++) counts_d[k] = '0;
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_SETUP;
      col_pos_q   <= '0;
      row_pos_q   <= '0;
      ccnt_q      <= '0;
      rcnt_q      <= '0;
      zc_q        <= '0;
      zr_q        <= '0;
      frames_q    <= '0;
      key_q       <= 1'b0;
      out_valid_q <= 1'b0;
      for (int k = 0; k < NZONES; k++) counts_q[k] <= '0;
    end else begin
      state_q     <= state_d;
      col_pos_q   <= col_pos_d;
      row_pos_q   <= row_pos_d;
      ccnt_q      <= ccnt_d;
      rcnt_q      <= rcnt_d;
      zc_q        <= zc_d;
      zr_q        <= zr_d;
      frames_q    <= frames_d;
      key_q       <= key_d;
      out_valid_q <= out_valid_d;
      counts_q    <= counts_d;
    end
  end

  always_ff @(posedge clk_i) begin
    area_q       <= area_d;
    sens_q       <= sens_d;
    sad_thr_q    <= sad_thr_d;
    cnt_thr_q    <= cnt_thr_d;
    out_motion_q <= out_motion_d;
    out_any_q    <= out_any_d;
    out_eval_q   <= out_eval_d;
  end

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = OUT_TDATA_W'({out_any_q, out_motion_q});
  assign m_axis_tuser  = out_eval_q;

endmodule

// ===== sv/zmd_checker.sv =====
`timescale 1ns / 1ps

module zmd_checker
  import zmd_pkg::*;
(
  input logic                   clk_i,
  input logic                   rst_ni,
  input logic                   s_axis_tvalid,
  input logic                   s_axis_tready,
  input logic                   s_axis_tlast,
  input logic                   m_axis_tvalid,
  input logic                   m_axis_tready,
  input logic [OUT_TDATA_W-1:0] m_axis_tdata,
  input logic                   m_axis_tuser,
  input logic                   cfg_we_i
);

  // hold a stalled result
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid)
    else $error("result dropped while stalled");

  a_any_motion: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid |-> m_axis_tdata[ENABLE_W] == |m_axis_tdata[ENABLE_W-1:0])
    else $error("any_motion disagrees with zone flags");

  a_skip_clean: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && !m_axis_tuser |-> m_axis_tdata[ENABLE_W:0] == '0)
    else $error("skipped frame reports motion");

  a_cfg_setup: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cfg_we_i |=> !s_axis_tready)
    else $error("input taken during threshold setup");

  a_frame_gap: assert property (@(posedge clk_i) disable iff (!rst_ni)
    s_axis_tvalid && s_axis_tready && s_axis_tlast |=> !s_axis_tready)
    else $error("input taken during zone evaluation");

endmodule

bind zone_motion_detector zmd_checker u_zmd_checker (.*);

// ===== tb/motion_verdict_check.sv =====
`timescale 1ns / 1ps

module motion_verdict_check
  import zmd_pkg::*;
(
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  logic                   s_axis_tvalid,
  input  logic                   s_axis_tready,
  input  logic [SAD_W-1:0]       s_axis_tdata,   // [15:0] sad
  input  logic                   s_axis_tuser,   // [0] key_frame
  input  logic                   s_axis_tlast,
  input  logic                   m_axis_tvalid,
  input  logic                   m_axis_tready,
  input  logic [OUT_TDATA_W-1:0] m_axis_tdata,   // [11:0] zone_motion, [12] any_motion
  input  logic                   m_axis_tuser,   // [0] evaluated
  input  logic                   cfg_we_i,
  input  logic [CFG_IDX_W-1:0]   cfg_idx_i,
  input  logic [CFG_DATA_W-1:0]  cfg_data_i,
  output int                     fail_count_o,
  output int                     pending_o
);

  localparam logic [LEVEL_W-1:0] LEVEL_NONE = LEVEL_W'(3);

  // sensitivity per frame-width tier (rows) and level (columns)
  localparam int LEVEL_SENS [4][3] = '{
    '{3, 5, 10}, '{7, 11, 20}, '{15, 25, 50}, '{35, 55, 95}
  };

  typedef struct packed {
    logic [ENABLE_W-1:0] zone_motion;
    logic                any_motion;
    logic                evaluated;
  } frame_verdict_t;

  frame_verdict_t verdict_q[$];

  logic [SIZE_W-1:0]   fw_reg, ww_reg, wh_reg;
  logic [ENABLE_W-1:0] zen_reg;
  logic                cen_reg;
  logic [LEVEL_W-1:0]  lvl_reg;
  logic [CVAL_W-1:0]   cval_reg;

  int col_pos, row_pos, frames_seen;
  int hit_count [NZONES];
  int mismatches = 0;

  function automatic int sensitivity_for(int fw);
    int s, tier;
    s    = 1;
    tier = (fw >= 120) ? 3 : (fw >= 80) ? 2 : (fw >= 40) ? 1 : 0;
    if (!cen_reg) begin
      if (lvl_reg != LEVEL_NONE) s = LEVEL_SENS[tier][int'(lvl_reg)];
    end else if (cval_reg == '0) begin
      s = 20;
    end else if (fw > 45) begin
      s = (int'(cval_reg) >= 20) ? int'(cval_reg) : 20;
    end else begin
      s = int'(cval_reg) / 5;
      if (s < 10) s = 10;
    end
    return (s == 0) ? 1 : s;
  endfunction

  // Accumulate one macroblock; at the frame end queue the zone verdict.
  function automatic void absorb_macroblock(logic [SAD_W-1:0] sad, logic key, logic last);
    int fw, ww, wh, area, sad_thr, count_thr, zc, zr, bit_idx;
    logic [ENABLE_W-1:0] motion;
    logic judged;
    frame_verdict_t v;
    fw = (fw_reg == '0) ? 1 : (int'(fw_reg) > MAX_FRAME_MB) ? MAX_FRAME_MB : int'(fw_reg);
    ww = (ww_reg == '0) ? 1 : int'(ww_reg);
    wh = (wh_reg == '0) ? 1 : int'(wh_reg);
    area = ww * wh;
    if (area >= 600)      sad_thr = 2500;
    else if (area >= 300) sad_thr = 3000;
    else if (area >= 100) sad_thr = 3500;
    else if (area >= 20)  sad_thr = 4000;
    else                  sad_thr = 4500;
    count_thr = area / sensitivity_for(fw);
    zc = col_pos / ww;
    zr = row_pos / wh;
    if (col_pos < fw && zc < ZONE_COLS && zr < ZONE_ROWS && int'(sad) > sad_thr) begin
      if (hit_count[zr * ZONE_COLS + zc] < CNT_MAX) hit_count[zr * ZONE_COLS + zc]++;
    end
    if (!last) begin
      col_pos++;
      if (col_pos >= fw) begin
        col_pos = 0;
        if (row_pos < MAX_FRAME_MB - 1) row_pos++;
      end
      return;
    end
    if (frames_seen < START_DELAY) frames_seen++;
    judged = !key && frames_seen >= START_DELAY;
    motion = '0;
    if (judged) begin
      for (int i = 0; i < ZONE_ROWS; i++) begin
        if (wh * i > row_pos) continue;
        for (int j = 0; j < ZONE_COLS; j++) begin
          bit_idx = (ZONE_ROWS - 1 - i) * ZONE_COLS + j;
          if (ww * j >= fw || bit_idx >= ENABLE_W) continue;
          if (!zen_reg[bit_idx]) continue;
          if (hit_count[i * ZONE_COLS + j] >= count_thr) motion[bit_idx] = 1'b1;
        end
      end
    end
    v.zone_motion = motion;
    v.any_motion  = (motion != '0);
    v.evaluated   = judged;
    verdict_q.push_back(v);
    col_pos = 0;
    row_pos = 0;
    for (int k = 0; k < NZONES; k++) hit_count[k] = 0;
  endfunction

  task automatic report_mismatch(string what, int got, int want);
    $display("MISMATCH %s: got 0x%0h, want 0x%0h at %0t", what, got, want, $time);
    mismatches++;
  endtask

  always @(posedge clk_i) begin
    frame_verdict_t want;
    if (!rst_ni) begin
      fw_reg      = FW_RST;
      ww_reg      = WW_RST;
      wh_reg      = WH_RST;
      zen_reg     = ZEN_RST;
      cen_reg     = CEN_RST;
      lvl_reg     = LVL_RST;
      cval_reg    = CVAL_RST;
      col_pos     = 0;
      row_pos     = 0;
      frames_seen = 0;
      for (int k = 0; k < NZONES; k++) hit_count[k] = 0;
      verdict_q.delete();
    end else begin
      if (cfg_we_i) begin
        case (cfg_idx_e'(cfg_idx_i))
          CFG_FRAME_WIDTH:   fw_reg   = cfg_data_i[SIZE_W-1:0];
          CFG_WINDOW_WIDTH:  ww_reg   = cfg_data_i[SIZE_W-1:0];
          CFG_WINDOW_HEIGHT: wh_reg   = cfg_data_i[SIZE_W-1:0];
          CFG_ZONE_ENABLE:   zen_reg  = cfg_data_i[ENABLE_W-1:0];
          CFG_CUSTOM_ENABLE: cen_reg  = cfg_data_i[0];
          CFG_SENS_LEVEL:    lvl_reg  = cfg_data_i[LEVEL_W-1:0];
          CFG_CUSTOM_VALUE:  cval_reg = cfg_data_i[CVAL_W-1:0];
          default: ;
        endcase
      end
      // a result leaving now always belongs to an earlier frame: pop before push
      if (m_axis_tvalid && m_axis_tready) begin
        if (verdict_q.size() == 0) begin
          report_mismatch("result with no frame pending", int'(m_axis_tdata), 0);
        end else begin
          want = verdict_q.pop_front();
          if (m_axis_tdata[ENABLE_W-1:0] !== want.zone_motion)
            report_mismatch("zone_motion", int'(m_axis_tdata[ENABLE_W-1:0]),
                            int'(want.zone_motion));
          if (m_axis_tdata[ENABLE_W] !== want.any_motion)
            report_mismatch("any_motion", int'(m_axis_tdata[ENABLE_W]), int'(want.any_motion));
          if (m_axis_tdata[OUT_TDATA_W-1:ENABLE_W+1] !== '0)
            report_mismatch("tdata padding", int'(m_axis_tdata[OUT_TDATA_W-1:ENABLE_W+1]), 0);
          if (m_axis_tuser !== want.evaluated)
            report_mismatch("evaluated", int'(m_axis_tuser), int'(want.evaluated));
        end
      end
      if (s_axis_tvalid && s_axis_tready)
        absorb_macroblock(s_axis_tdata, s_axis_tuser, s_axis_tlast);
    end
    fail_count_o <= mismatches;
    pending_o    <= verdict_q.size();
  end

endmodule

// ===== tb/tb_top.sv =====
`timescale 1ns / 1ps

module tb_top;
  import zmd_pkg::*;

  localparam int ITEM_TARGET = 1800;
  localparam int IDLE_LIMIT  = 20000;
  localparam int LONG_HOLD   = 400;
  localparam int SETTLE      = 4;

  localparam int FW_CORNERS [13] = '{0, 1, 39, 40, 45, 46, 79, 80, 119, 120, 128, 129, 255};
  localparam int WIN_CORNERS [12][2] = '{
    '{0, 0}, '{1, 1}, '{5, 4}, '{19, 1}, '{20, 1}, '{10, 10},
    '{20, 15}, '{24, 25}, '{128, 128}, '{255, 255}, '{30, 22}, '{2, 50}
  };
  localparam int CVAL_CORNERS [10] = '{0, 1, 19, 20, 49, 50, 54, 55, 99, 1023};

  typedef enum logic [1:0] {RX_OPEN, RX_COIN, RX_SPARSE, RX_PERIODIC} rx_mode_e;

  logic                   clk_i         = 1'b0;
  logic                   rst_ni        = 1'b0;
  logic                   s_axis_tvalid = 1'b0;
  logic                   s_axis_tready;
  logic [SAD_W-1:0]       s_axis_tdata  = '0;
  logic                   s_axis_tuser  = 1'b0;
  logic                   s_axis_tlast  = 1'b0;
  logic                   m_axis_tvalid;
  logic                   m_axis_tready = 1'b0;
  logic [OUT_TDATA_W-1:0] m_axis_tdata;
  logic                   m_axis_tuser;
  logic                   cfg_we_i      = 1'b0;
  logic [CFG_IDX_W-1:0]   cfg_idx_i     = '0;
  logic [CFG_DATA_W-1:0]  cfg_data_i    = '0;

  int fail_count;
  int pending;

  int items_sent  = 0;
  int frames_sent = 0;
  int burst_left  = 0;
  int fw_now      = 120;
  int hold_seq    = 0;
  int idle_cycles = 0;

  zone_motion_detector dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .s_axis_tlast  (s_axis_tlast),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser),
    .cfg_we_i      (cfg_we_i),
    .cfg_idx_i     (cfg_idx_i),
    .cfg_data_i    (cfg_data_i)
  );

  motion_verdict_check verdict_check (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .s_axis_tlast  (s_axis_tlast),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser),
    .cfg_we_i      (cfg_we_i),
    .cfg_idx_i     (cfg_idx_i),
    .cfg_data_i    (cfg_data_i),
    .fail_count_o  (fail_count),
    .pending_o     (pending)
  );

  always begin
    #10 clk_i = 1'b1;
    #10 clk_i = 1'b0;
  end

  always @(posedge clk_i) begin
    if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready) || cfg_we_i)
      idle_cycles <= 0;
    else
      idle_cycles <= idle_cycles + 1;
  end

  initial begin
    while (idle_cycles < IDLE_LIMIT) @(posedge clk_i);
    $display("*** FAILED ***");
    $finish;
  end

  // Receiver: stall pattern of its own, plus a long hold-off on request.
  rx_mode_e rx_mode      = RX_OPEN;
  int       rx_mode_left = 0;
  int       rx_tick      = 0;
  int       hold_seen    = 0;
  int       hold_left    = 0;

  always @(posedge clk_i) begin
    rx_tick <= rx_tick + 1;
    if (hold_left > 0) begin
      hold_left     <= hold_left - 1;
      m_axis_tready <= 1'b0;
    end else if (hold_seen != hold_seq) begin
      hold_seen     <= hold_seq;
      hold_left     <= LONG_HOLD;
      m_axis_tready <= 1'b0;
    end else begin
      if (rx_mode_left == 0) begin
        rx_mode      <= rx_mode_e'($urandom_range(0, 3));
        rx_mode_left <= $urandom_range(20, 300);
      end else begin
        rx_mode_left <= rx_mode_left - 1;
      end
      case (rx_mode)
        RX_OPEN:     m_axis_tready <= 1'b1;
        RX_COIN:     m_axis_tready <= 1'($urandom_range(0, 1));
        RX_SPARSE:   m_axis_tready <= ($urandom_range(0, 7) == 0);
        RX_PERIODIC: m_axis_tready <= ((rx_tick % 5) < 2);
        default:     m_axis_tready <= 1'b1;
      endcase
    end
  end

  function automatic logic [SAD_W-1:0] pick_sad();
    int r;
    r = $urandom_range(0, 9);
    if (r < 3) return SAD_W'($urandom_range(0, 2000));
    // land on or next to one of the tier thresholds
    if (r < 6) return SAD_W'(2499 + 500 * $urandom_range(0, 4) + $urandom_range(0, 2));
    return SAD_W'($urandom_range(0, 65535));
  endfunction

  task automatic cfg_write(cfg_idx_e idx, logic [CFG_DATA_W-1:0] data);
    cfg_we_i   <= 1'b1;
    cfg_idx_i  <= idx;
    cfg_data_i <= data;
    @(posedge clk_i);
  endtask

  // Write every register; bits above each register's width are random.
  task automatic apply_settings(logic [7:0] fw, logic [7:0] ww, logic [7:0] wh,
                                logic [11:0] zen, logic cen, logic [1:0] lvl,
                                logic [9:0] cval);
    cfg_write(CFG_FRAME_WIDTH,   {4'($urandom_range(0, 15)), fw});
    cfg_write(CFG_WINDOW_WIDTH,  {4'($urandom_range(0, 15)), ww});
    cfg_write(CFG_WINDOW_HEIGHT, {4'($urandom_range(0, 15)), wh});
    cfg_write(CFG_ZONE_ENABLE,   zen);
    cfg_write(CFG_CUSTOM_ENABLE, {11'($urandom_range(0, 2047)), cen});
    cfg_write(CFG_SENS_LEVEL,    {10'($urandom_range(0, 1023)), lvl});
    cfg_write(CFG_CUSTOM_VALUE,  {2'($urandom_range(0, 3)), cval});
    cfg_we_i <= 1'b0;
    fw_now = (fw == 8'd0) ? 1 : (int'(fw) > MAX_FRAME_MB) ? MAX_FRAME_MB : int'(fw);
  endtask

  task automatic send_mb(logic [SAD_W-1:0] sad, logic key, logic last);
    int gap;
    if (burst_left == 0) begin
      if ($urandom_range(0, 3) == 0) begin
        gap        = 0;
        burst_left = $urandom_range(50, 120);
      end else begin
        gap        = $urandom_range(0, 5);
        burst_left = $urandom_range(1, 12);
      end
      if (gap > 0) begin
        s_axis_tvalid <= 1'b0;
        repeat (gap) @(posedge clk_i);
      end
    end
    burst_left--;
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= sad;
    s_axis_tuser  <= key;
    s_axis_tlast  <= last;
    do @(posedge clk_i); while (!s_axis_tready);
    items_sent++;
  endtask

  // key_frame matters only on the last transfer; randomize it elsewhere
  task automatic send_frame(int len, logic key);
    for (int k = 0; k < len; k++)
      send_mb(pick_sad(), (k == len - 1) ? key : 1'($urandom_range(0, 1)), k == len - 1);
    frames_sent++;
  endtask

  // Drop valid and hold until every frame result has left, then let the block settle.
  task automatic quiesce();
    s_axis_tvalid <= 1'b0;
    burst_left = 0;
    @(posedge clk_i);
    while (pending != 0) @(posedge clk_i);
    repeat (SETTLE) @(posedge clk_i);
  endtask

  initial begin
    logic [7:0]  fw, ww, wh;
    logic [11:0] zen;
    logic [9:0]  cval;
    int          pick, n_frames, len, rows;
    bit          hold_done, tall_done;
    hold_done = 1'b0;
    tall_done = 1'b0;

    repeat (9) @(posedge clk_i);
    rst_ni <= 1'b1;
    repeat (2) @(posedge clk_i);

    // Directed: SAD extremes and tier edges, key frame, single-item frame.
    apply_settings(8'd4, 8'd1, 8'd1, 12'hFFF, 1'b0, 2'($urandom_range(0, 3)), 10'd0);
    send_mb(16'h0000, 1'b0, 1'b0);
    send_mb(16'hFFFF, 1'b0, 1'b0);
    send_mb(16'd4500, 1'b0, 1'b0);
    send_mb(16'd4501, 1'b1, 1'b1);
    frames_sent += 1;
    send_mb(16'hFFFF, 1'b0, 1'b1);
    frames_sent += 1;
    foreach (FW_CORNERS[i]) begin
      if (i < 10) send_mb(SAD_W'(2500 + 500 * (i / 2) + (i % 2)), 1'b0, 1'b0);
    end
    send_mb(16'h5555, 1'b0, 1'b0);
    send_mb(16'hAAAA, 1'b0, 1'b1);
    frames_sent += 1;
    quiesce();
    // zero sizes are used as one, custom value at its top
    apply_settings(8'd0, 8'd0, 8'd0, 12'h000, 1'b1, 2'($urandom_range(0, 3)), 10'h3FF);
    send_frame(3, 1'b1);
    quiesce();
    apply_settings(8'd255, 8'd255, 8'd255, 12'hA5A, 1'b0, 2'($urandom_range(0, 3)), 10'd1);
    send_frame(4, 1'b0);

    while (items_sent < ITEM_TARGET) begin
      quiesce();
      if (!hold_done && frames_sent >= START_DELAY + 20) begin
        // long receiver hold-off while frames keep coming: the input must stall
        hold_done = 1'b1;
        apply_settings(8'd2, 8'd1, 8'd1, 12'hFFF, 1'($urandom_range(0, 1)),
                       2'($urandom_range(0, 3)), 10'($urandom_range(0, 1023)));
        hold_seq <= hold_seq + 1;
        repeat (8) send_frame(2, 1'b0);
        continue;
      end
      if (!tall_done && frames_sent >= START_DELAY + 40) begin
        // frame taller than the row counter: row position saturates
        tall_done = 1'b1;
        apply_settings(8'd1, 8'd1, 8'd40, 12'hFFF, 1'b1, 2'($urandom_range(0, 3)), 10'd0);
        send_frame(140, 1'b0);
        continue;
      end

      if ($urandom_range(0, 9) < 7) fw = 8'($urandom_range(1, 8));
      else fw = 8'(FW_CORNERS[$urandom_range(0, 12)]);
      if ($urandom_range(0, 9) < 7) begin
        ww = 8'($urandom_range(1, 3));
        wh = 8'($urandom_range(1, 3));
      end else begin
        pick = $urandom_range(0, 11);
        ww   = 8'(WIN_CORNERS[pick][0]);
        wh   = 8'(WIN_CORNERS[pick][1]);
      end
      pick = $urandom_range(0, 9);
      if (pick < 6)      zen = 12'($urandom_range(0, 4095));
      else if (pick < 8) zen = 12'hFFF;
      else if (pick < 9) zen = 12'h000;
      else               zen = 12'(1 << $urandom_range(0, 11));
      if ($urandom_range(0, 9) < 6) cval = 10'($urandom_range(0, 1023));
      else cval = 10'(CVAL_CORNERS[$urandom_range(0, 9)]);
      apply_settings(fw, ww, wh, zen, 1'($urandom_range(0, 1)), 2'($urandom_range(0, 3)), cval);

      n_frames = $urandom_range(4, 12);
      repeat (n_frames) begin
        if (frames_sent < START_DELAY) begin
          len = $urandom_range(1, 3);
        end else if (fw_now <= 8) begin
          rows = $urandom_range(1, (fw_now <= 4) ? 8 : 4);
          len  = fw_now * rows;
          if ($urandom_range(0, 3) == 0) len += $urandom_range(0, fw_now - 1);
        end else begin
          len = $urandom_range(1, 30);
        end
        send_frame(len, $urandom_range(0, 6) == 0);
      end
    end

    quiesce();
    repeat (10) @(posedge clk_i);
    if (fail_count == 0 && pending == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("*** FAILED ***");
    end
    $finish;
  end

endmodule
